@@ design/cursor_tape_store_core_assert.svh @@
// Assertion macros shared by the cursor tape store RTL.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef CURSOR_TAPE_STORE_CORE_ASSERT_SVH
`define CURSOR_TAPE_STORE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cts_pkg.sv @@
// Shared constants and types of the cursor tape store.
// No dependencies; used by every module of the block but cts_ram.
`timescale 1ns / 1ps

package cts_pkg;

  localparam int CTS_DEPTH = 64;
  localparam int CMD_W     = 3;
  localparam int ELEM_W    = 8;
  localparam int ERR_W     = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_REWIND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STOP = 2'd2;

  // Fixed-width part of one result transaction.
  typedef struct packed {
    logic [ELEM_W-1:0] current_element;
    logic              element_valid;
    logic              at_start;
    logic              at_stop;
    logic [ERR_W-1:0]  error_code;
  } cts_result_t;

endpackage

@@ design/cursor_tape_store_core.sv @@
// Top level of the cursor tape store: sequencer, element RAM and output register.
// Depends on cts_pkg, cts_ram, cts_ctrl, cts_out and the assertion macro header.
`timescale 1ns / 1ps
`include "cursor_tape_store_core_assert.svh"

// The block keeps up to DEPTH bytes as a gap buffer in one RAM: the elements
// before the cursor at the bottom, the cursor element and those after it at the
// top, so erasing or inserting left never moves stored data. It works on one
// command at a time. Report, erase, insert left and any command that ends in an
// error go through the fetch and result states; step first moves one element
// across the gap through the RAM's registered read, and insert right then writes
// the new element in a put state; rewind moves the elements before the cursor,
// one per RAM read-write pair. The next command is accepted after the result
// enters the output register; a new command is taken while the previous result
// still waits on the master side. Reset clears the pointers and control state
// only; no RAM clearing is needed.
module cursor_tape_store_core #(
  parameter int DEPTH = cts_pkg::CTS_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int TW = ((cts_pkg::ELEM_W + 3 + CW + cts_pkg::ERR_W + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // s_tdata, from bit 0: command[2:0], element[7:0], zero padding.
  input  logic [15:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // m_tdata, from bit 0: current_element, element_valid, at_start, at_stop,
  // length, error_code, zero padding.
  output logic [TW-1:0] m_tdata
);

  import cts_pkg::*;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [ELEM_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  cts_result_t       res;
  logic [CW-1:0]     res_length;

  // Command sequencer.
  cts_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s_tvalid),
    .cmd_ready  (s_tready),
    .command    (s_tdata[CMD_W-1:0]),
    .element    (s_tdata[CMD_W+ELEM_W-1:CMD_W]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .res_length (res_length)
  );

  // Element store.
  cts_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register on the master side.
  cts_out #(.CW(CW)) u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .res_length (res_length),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // One command in flight: the sequencer is busy right after taking one.
  `CTS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second command accepted while busy")
  // A cursor-at-stop error leaves the cursor at stop.
  `CTS_ASSERT_NOW(a_stop_err_at_stop, res_valid && (res.error_code == ERR_STOP), res.at_stop, "stop error with cursor on an element")
  // The stored length never exceeds the capacity.
  `CTS_ASSERT_NOW(a_len_bound, res_valid, res_length <= CW'(DEPTH), "length beyond capacity")
  // RAM writes stay inside the store.
  `CTS_ASSERT_NOW(a_waddr_bound, mem_we, {1'b0, mem_waddr} <= (AW + 1)'(DEPTH - 1), "RAM write outside the store")

endmodule

@@ design/cts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered from the read address; a read of the entry
  // being written in the same cycle returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cts_ctrl.sv @@
// Command sequencer of the cursor tape store: gap buffer pointers and RAM accesses.
// Depends on cts_pkg; drives the element RAM and hands results to cts_out.
`timescale 1ns / 1ps

module cts_ctrl #(
  parameter int DEPTH = cts_pkg::CTS_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [cts_pkg::CMD_W-1:0]  command,
  input  logic [cts_pkg::ELEM_W-1:0] element,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [cts_pkg::ELEM_W-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [cts_pkg::ELEM_W-1:0] mem_rdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output cts_pkg::cts_result_t       res,
  output logic [CW-1:0]              res_length
);

  import cts_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MOVE_RD = 3'd1;
  localparam logic [2:0] ST_MOVE_WR = 3'd2;
  localparam logic [2:0] ST_PUT     = 3'd3;
  localparam logic [2:0] ST_FETCH   = 3'd4;
  localparam logic [2:0] ST_RESULT  = 3'd5;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // The left part (before the cursor) sits at the bottom of the RAM, the right
  // part (cursor element and after) at the top. lpos is the cursor position.
  logic [2:0]        state, state_next;
  logic [CW-1:0]     lpos, lpos_next;
  logic [CW-1:0]     rlen, rlen_next;
  logic [ERR_W-1:0]  err, err_next;
  logic              back, back_next;
  logic              put, put_next;
  logic [ELEM_W-1:0] elem_q, elem_q_next;

  logic [CW-1:0] cnt;
  logic          stop;
  logic          full;
  logic [CW-1:0] right_head;
  logic [CW-1:0] right_slot;

  assign cnt        = lpos + rlen;
  assign stop       = (rlen == '0);
  assign full       = (cnt == DEPTH_C);
  assign right_head = DEPTH_C - rlen;
  assign right_slot = DEPTH_C - rlen - ONE_C;

  assign cmd_ready = (state == ST_IDLE);

  // Next-state and RAM access logic.
  always_comb begin
    state_next  = state;
    lpos_next   = lpos;
    rlen_next   = rlen;
    err_next    = err;
    back_next   = back;
    put_next    = put;
    elem_q_next = elem_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = AW'(right_head);
    res_valid   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          elem_q_next = element;
          err_next    = ERR_NONE;
          back_next   = 1'b0;
          put_next    = 1'b0;
          state_next  = ST_FETCH;
          unique case (command)
            CMD_REWIND: begin
              if (lpos != '0) begin
                back_next  = 1'b1;
                state_next = ST_MOVE_RD;
              end
            end
            CMD_STEP: begin
              if (stop) begin
                err_next = ERR_STOP;
              end else begin
                state_next = ST_MOVE_RD;
              end
            end
            CMD_INSL: begin
              if (full) begin
                err_next = ERR_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(right_slot);
                mem_wdata = element;
                rlen_next = rlen + ONE_C;
              end
            end
            CMD_INSR: begin
              if (cnt == '0) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(DEPTH_C - ONE_C);
                mem_wdata = element;
                rlen_next = ONE_C;
              end else if (stop) begin
                err_next = ERR_STOP;
              end else if (full) begin
                err_next = ERR_FULL;
              end else begin
                put_next   = 1'b1;
                state_next = ST_MOVE_RD;
              end
            end
            CMD_ERASE: begin
              if (stop) begin
                err_next = ERR_STOP;
              end else begin
                rlen_next = rlen - ONE_C;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE_RD: begin
        // Read the element that crosses the gap.
        mem_raddr  = back ? AW'(lpos - ONE_C) : AW'(right_head);
        state_next = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (back) begin
          mem_waddr  = AW'(right_slot);
          lpos_next  = lpos - ONE_C;
          rlen_next  = rlen + ONE_C;
          state_next = (lpos == ONE_C) ? ST_FETCH : ST_MOVE_RD;
        end else begin
          // An insert right keeps the right length: the new element takes the slot.
          mem_waddr  = AW'(lpos);
          lpos_next  = lpos + ONE_C;
          rlen_next  = put ? rlen : (rlen - ONE_C);
          state_next = put ? ST_PUT : ST_FETCH;
        end
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(right_head);
        mem_wdata  = elem_q;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result fields; the RAM keeps reading the cursor element while the result waits.
  always_comb begin
    res.current_element = stop ? '0 : mem_rdata;
    res.element_valid   = !stop;
    res.at_start        = (lpos == '0);
    res.at_stop         = stop;
    res.error_code      = err;
  end
  assign res_length = cnt;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lpos  <= '0;
      rlen  <= '0;
      err   <= ERR_NONE;
      back  <= 1'b0;
      put   <= 1'b0;
    end else begin
      state <= state_next;
      lpos  <= lpos_next;
      rlen  <= rlen_next;
      err   <= err_next;
      back  <= back_next;
      put   <= put_next;
    end
  end

  always_ff @(posedge clk) begin
    elem_q <= elem_q_next;
  end

endmodule

@@ design/cts_out.sv @@
// Output register of the cursor tape store: packs and holds one result transaction.
// Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_out #(
  parameter int CW = 7,
  localparam int FIELD_BITS = cts_pkg::ELEM_W + 3 + CW + cts_pkg::ERR_W,
  localparam int TW = ((FIELD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  cts_pkg::cts_result_t res,
  input  logic [CW-1:0]        res_length,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata, from bit 0: current_element, element_valid, at_start, at_stop,
  // length, error_code, zero padding.
  output logic [TW-1:0]        m_tdata
);

  import cts_pkg::*;

  logic [FIELD_BITS-1:0] packed_fields;

  assign res_ready = !m_tvalid || m_tready;

  assign packed_fields = {res.error_code, res_length, res.at_stop, res.at_start,
                          res.element_valid, res.current_element};

  // Valid flag of the held transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload is loaded only when the slot is free or its transaction is being taken.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= TW'(packed_fields);
    end
  end

endmodule
